// ===== sv/srtc_pkg.sv =====
// Shared types and constants of the shared-ride tour cost block.
package srtc_pkg;

  localparam int VERTEX_W = 6;
  localparam int EDGE_W   = 32;
  localparam int COST_W   = 54;
  localparam int LIMIT_W  = 21;
  localparam int CNT_W    = 7;
  localparam int EPOCH_W  = 8;
  localparam int DIV_STEPS = 3;    // quotient bits per divider cycle
  localparam int QDEPTH   = 2;     // front-to-back queue entries

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_FRAC_BITS    = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                pickup;
    logic [VERTEX_W-1:0] dest_vertex;
    logic [EDGE_W-1:0]   edge_cost;
    logic                last_position;
  } srtc_in_t;

  typedef struct packed {
    logic [COST_W-1:0] tour_cost;
    logic [COST_W-1:0] best_cost;
    logic              new_best;
    logic              budget_exhausted;
  } srtc_out_t;

endpackage

// ===== sv/srtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/srtc_div.sv =====
// Iterative restoring divider, DIV_STEPS quotient bits per cycle.
module srtc_div
  import srtc_pkg::*;
#(
  parameter int DW = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DW-1:0]        dividend,
  input  logic [CNT_W:0]       divisor,
  output logic                 done,
  output logic [((DW+DIV_STEPS-1)/DIV_STEPS)*DIV_STEPS-1:0] quotient
);

  localparam int QW   = ((DW + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int ITER = QW / DIV_STEPS;
  localparam int CW   = $clog2(ITER + 1);
  localparam int DVW  = CNT_W + 1;

  logic [QW-1:0]  quo_r, quo_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] div_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;

  // remainder stays below the divisor, so DVW+1 bits hold each trial
  always_comb begin
    logic [DVW:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial   = {rem_nxt, quo_nxt[QW-1]};
      quo_nxt = {quo_nxt[QW-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        trial      = trial - {1'b0, div_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DVW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // one-cycle pulse after the last iteration
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ITER);
        quo_r  <= QW'(dividend);
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/srtc_front.sv =====
// Front end: accepts tour positions, folds vertex numbers onto the store, queues them.
module srtc_front
  import srtc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  srtc_in_t                        in_data,
  input  logic                            hold,
  output logic                            q_valid,
  input  logic                            q_ready,
  output logic [$clog2(MAX_VERTICES)-1:0] q_vaddr,
  output logic [$clog2(MAX_VERTICES)-1:0] q_daddr,
  output logic                            q_pickup,
  output logic [EDGE_W-1:0]               q_edge,
  output logic                            q_last
);

  localparam int AW     = $clog2(MAX_VERTICES);
  localparam int VCODES = 1 << VERTEX_W;
  localparam int PW     = $clog2(QDEPTH);
  localparam int NW     = $clog2(QDEPTH + 1);

  // vertex code modulo MAX_VERTICES
  logic [AW-1:0] mod_tbl [VCODES];
  for (genvar i = 0; i < VCODES; i++) begin : g_mod
    assign mod_tbl[i] = AW'(i % MAX_VERTICES);
  end

  logic [AW-1:0]     vaddr_q [QDEPTH];
  logic [AW-1:0]     daddr_q [QDEPTH];
  logic              pick_q  [QDEPTH];
  logic [EDGE_W-1:0] edge_q  [QDEPTH];
  logic              last_q  [QDEPTH];

  logic [PW-1:0] wptr_r, rptr_r;
  logic [NW-1:0] fill_r;
  logic          push, pop;

  assign in_ready = (fill_r != NW'(QDEPTH)) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != '0);
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      vaddr_q[wptr_r] <= mod_tbl[in_data.vertex];
      daddr_q[wptr_r] <= mod_tbl[in_data.dest_vertex];
      pick_q[wptr_r]  <= in_data.pickup;
      edge_q[wptr_r]  <= in_data.edge_cost;
      last_q[wptr_r]  <= in_data.last_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(QDEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(QDEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + NW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - NW'(1);
      end
    end
  end

  assign q_vaddr  = vaddr_q[rptr_r];
  assign q_daddr  = daddr_q[rptr_r];
  assign q_pickup = pick_q[rptr_r];
  assign q_edge   = edge_q[rptr_r];
  assign q_last   = last_q[rptr_r];

endmodule

// ===== sv/srtc_back.sv =====
// Back end: drop-off store, occupancy, divider, cost sum, budget and result register.
module srtc_back
  import srtc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  logic [$clog2(MAX_VERTICES)-1:0] q_vaddr,
  input  logic [$clog2(MAX_VERTICES)-1:0] q_daddr,
  input  logic                            q_pickup,
  input  logic [EDGE_W-1:0]               q_edge,
  input  logic                            q_last,
  output logic                            sweeping,
  input  logic                            cfg_we,
  input  logic [LIMIT_W-1:0]              cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output srtc_out_t                       out_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int DW = EDGE_W + FRAC_BITS;
  localparam int QW = ((DW + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int SW = ((COST_W > QW) ? COST_W : QW) + 1;
  localparam int MW = EPOCH_W + CNT_W;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDD   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      sweep_r;
  logic [EPOCH_W-1:0] epoch_r;

  logic [AW-1:0]      daddr_r;
  logic               pick_r;
  logic [EDGE_W-1:0]  edge_r;
  logic               last_r;

  logic [CNT_W-1:0]   occ_r;
  logic [COST_W-1:0]  run_r;
  logic [COST_W-1:0]  best_r;
  logic               best_valid_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] calls_r;

  logic               out_valid_r;
  srtc_out_t          out_r;

  // store port
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [MW-1:0]      mem_wdata, mem_rdata;
  logic [CNT_W-1:0]   cnt_rd;

  // divider
  logic               div_start, div_done;
  logic [CNT_W:0]     divisor;
  logic [QW-1:0]      quo;

  logic [CNT_W-1:0]   occ_sub, occ_upd;
  logic [CNT_W-1:0]   cnt_inc;
  logic [SW-1:0]      sum;
  logic [COST_W-1:0]  run_add;

  logic               slot_free;
  logic               tour_end;
  logic [LIMIT_W-1:0] calls_dec;
  logic               refused, better, take_best;

  srtc_ram #(.WIDTH(MW), .DEPTH(MAX_VERTICES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  srtc_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({edge_r, {FRAC_BITS{1'b0}}}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // entries tagged with an older epoch count as zero
  assign cnt_rd  = (mem_rdata[MW-1:CNT_W] == epoch_r) ? mem_rdata[CNT_W-1:0] : '0;
  assign occ_sub = (cnt_rd >= occ_r) ? '0 : occ_r - cnt_rd;
  assign occ_upd = (pick_r && occ_r != CNT_MAX) ? occ_r + CNT_W'(1) : occ_r;
  assign cnt_inc = (cnt_rd != CNT_MAX) ? cnt_rd + CNT_W'(1) : cnt_rd;
  assign divisor = {1'b0, occ_upd} + (CNT_W + 1)'(1);

  assign sum     = SW'(run_r) + SW'(quo);
  assign run_add = (sum > SW'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];

  assign q_ready   = (state_r == S_IDLE);
  assign sweeping  = (state_r == S_SWEEP);
  assign div_start = (state_r == S_UPD);
  assign mem_raddr = (state_r == S_IDLE) ? q_vaddr : daddr_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = daddr_r;
    mem_wdata = {epoch_r, cnt_inc};
    if (state_r == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_r;
      mem_wdata = '0;
    end else if (state_r == S_UPD) begin
      mem_we = pick_r;
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign tour_end  = (state_r == S_DONE) && slot_free;
  assign calls_dec = (calls_r != '0) ? calls_r - LIMIT_W'(1) : '0;
  assign refused   = (limit_r != '0) && (calls_dec == '0);
  assign better    = !best_valid_r || (best_r > run_r);
  assign take_best = !refused && better;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sweep_r == AW'(MAX_VERTICES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) state_nxt = S_RDD;
      end
      S_RDD: state_nxt = S_UPD;
      S_UPD: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = last_r ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        if (slot_free) state_nxt = (epoch_r == '1) ? S_SWEEP : S_IDLE;
      end
      default: state_nxt = S_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_r      <= '0;
      epoch_r      <= EPOCH_W'(1);
      occ_r        <= '0;
      run_r        <= '0;
      best_valid_r <= 1'b0;
      best_r       <= '0;
      limit_r      <= '0;
      calls_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (tour_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_SWEEP: begin
          sweep_r <= (sweep_r == AW'(MAX_VERTICES - 1)) ? '0 : sweep_r + AW'(1);
          if (sweep_r == AW'(MAX_VERTICES - 1)) begin
            epoch_r <= EPOCH_W'(1);
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            daddr_r <= q_daddr;
            pick_r  <= q_pickup;
            edge_r  <= q_edge;
            last_r  <= q_last;
          end
        end
        S_RDD: occ_r <= occ_sub;
        S_UPD: occ_r <= occ_upd;
        S_DIV: begin
          if (div_done) run_r <= run_add;
        end
        S_DONE: begin
          if (slot_free) begin
            out_r.tour_cost        <= refused ? '0 : run_r;
            out_r.best_cost        <= take_best ? run_r :
                                      (best_valid_r ? best_r : '0);
            out_r.new_best         <= take_best;
            out_r.budget_exhausted <= refused;
            occ_r <= '0;
            run_r <= '0;
            if (epoch_r != '1) epoch_r <= epoch_r + EPOCH_W'(1);
          end
        end
        default: ;
      endcase

      // budget load wins over a tour end in the same cycle
      if (cfg_we) begin
        limit_r      <= cfg_wdata;
        calls_r      <= cfg_wdata;
        best_valid_r <= 1'b0;
        best_r       <= '0;
      end else if (tour_end) begin
        if (limit_r != '0) calls_r <= calls_dec;
        if (take_best) begin
          best_r       <= run_r;
          best_valid_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/shared_ride_tour_cost.sv =====
// Top level of the shared-ride tour cost block.
//
// Usage: feed one tour position per transaction on in_valid/in_ready/in_data.
// Each position updates the vehicle occupancy from a per-vertex drop-off
// store and adds edge_cost / (1 + occupancy) in fixed point (FRAC_BITS
// fraction bits, truncated, saturating at 54 bits) to the running cost.
// A position marked last_position yields one result transaction on
// out_valid/out_ready/out_data: tour total, best total, new-best flag and
// budget-exhausted flag; other positions yield none.
// cfg_we/cfg_wdata load the evaluation budget (0 = unlimited) and clear the
// best total; write only while the block is idle.
// The back end takes a new position only once the last one has passed the
// two store reads and the three-bit-per-cycle divider. The front queue
// takes in up to two positions ahead of the back end; a finished result
// waits in the output register.
// Reset: a clearing pass through all MAX_VERTICES entries of the drop-off
// store runs with in_ready low; the pass repeats after every 255 tours.
// A stalled receiver holds the result; the back end then waits at the next
// tour end, and the queue fills and drops in_ready.
module shared_ride_tour_cost
  import srtc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srtc_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output srtc_out_t          out_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_VERTICES);

  // queue head toward the back end
  logic              q_valid, q_ready;
  logic [AW-1:0]     q_vaddr, q_daddr;
  logic              q_pickup, q_last;
  logic [EDGE_W-1:0] q_edge;
  logic              sweeping;

  srtc_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .hold     (sweeping),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_vaddr  (q_vaddr),
    .q_daddr  (q_daddr),
    .q_pickup (q_pickup),
    .q_edge   (q_edge),
    .q_last   (q_last)
  );

  srtc_back #(.MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_vaddr   (q_vaddr),
    .q_daddr   (q_daddr),
    .q_pickup  (q_pickup),
    .q_edge    (q_edge),
    .q_last    (q_last),
    .sweeping  (sweeping),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
